// ===== rtl/core/nurbs_curve_point_eval_unit_macros.svh =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - assertion macros
// Concurrent checks, present in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef NURBS_CURVE_POINT_EVAL_UNIT_MACROS_SVH
`define NURBS_CURVE_POINT_EVAL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// assert that prop holds at every clock edge outside reset
`define NCPE_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ncpe assertion failed");
// assert that cond never holds outside reset
`define NCPE_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ncpe forbidden condition");
`else
`define NCPE_ASSERT(name, clk, rst, prop)
`define NCPE_NEVER(name, clk, rst, cond)
`endif
`endif

// ===== rtl/core/ncpe_pkg.sv =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - shared package
// Word types, codes and sizes used across the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ncpe_pkg;

   localparam int MaxDegree = 3;
   localparam int MaxPoints = 64;
   localparam int KnotDepth = MaxPoints + MaxDegree + 1;

   localparam int KnotW    = 24;
   localparam int CoordW   = 32;
   localparam int WeightW  = 16;
   localparam int SlotW    = 7;
   localparam int KnotIdxW = $clog2(KnotDepth);
   localparam int PtIdxW   = $clog2(MaxPoints);
   localparam int DegW     = 2;
   localparam int CountW   = 7;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 7;

   localparam int DivW     = 64;
   localparam int DvsW     = 32;
   localparam int DivCntW  = $clog2(DivW);

   localparam logic [CsrIdxW-1:0] CSR_DEGREE = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_COUNT  = 1'b1;

   typedef enum logic [1:0] {
      OP_KNOT  = 2'd0,
      OP_POINT = 2'd1,
      OP_EVAL  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_ZERO_W = 2'd1,
      STAT_SAT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]               opcode;
      logic [SlotW-1:0]         slot;
      logic [KnotW-1:0]         param_value;
      logic signed [CoordW-1:0] coord_x;
      logic signed [CoordW-1:0] coord_y;
      logic signed [CoordW-1:0] coord_z;
      logic [WeightW-1:0]       point_weight;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
      logic signed [CoordW-1:0] pos_z;
      status_type               status;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic signed [DivW-1:0] dividend;
      logic signed [DvsW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic signed [DivW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_RD_HI, S_RD_LO, S_CLAMP, S_PROBE, S_CMP, S_LR_RD, S_LR_CAP,
      S_TRI_DEN, S_TRI_MUL1, S_TRI_GO1, S_TRI_W1, S_TRI_MUL2, S_TRI_GO2,
      S_TRI_W2, S_TRI_NEXT, S_PT_RD, S_WN_MUL, S_WN_SHIFT, S_MX, S_MY, S_MZ,
      S_AZ, S_FIN, S_FGO, S_FW, S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/nurbs_curve_point_eval_unit.sv =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - top level
// Evaluates one point of a rational B-spline curve in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item: knot write, control point write or
//   evaluate. A write word produces no response; an evaluate word produces
//   exactly one rsp_* word with x, y, z (Q16.16, saturated) and a status.
//   csr_* sets degree and point count; change them only while idle.
// Timing:
//   Words wait in a two-entry queue; the back end takes one at a time.
//   An evaluate reads the end knots, clamps t or bisects for the span (no
//   probes when t is clamped), reads the knot differences, builds the basis
//   triangle, sums the weighted points and divides by the weight sum.
//   The shared 64-step radix-2 divider dominates the run time: two divisions
//   per basis term with a nonzero denominator, one per coordinate.
// Reset:
//   Synchronous, active high: clears the queue, the sequencer and the
//   response valid flag and sets degree 1, point count 2. Knot and point
//   stores keep whatever they hold and must be written before use.
// Backpressure:
//   A finished response waits in the output register while rsp_ready is
//   low; the queue keeps taking words until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module nurbs_curve_point_eval_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire ncpe_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output ncpe_pkg::rsp_type            rsp_data,
   input  wire                          csr_we,
   input  wire [ncpe_pkg::CsrIdxW-1:0]  csr_index,
   input  wire [ncpe_pkg::CsrDataW-1:0] csr_wdata
);

   // queue between front and back
   logic                  q_valid;
   logic                  q_ready;
   ncpe_pkg::req_type     q_data;

   // shared divider
   ncpe_pkg::div_req_type div_req;
   ncpe_pkg::div_rsp_type div_rsp;

   // front: drop no-op and out-of-range words, queue the rest
   ncpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data)
   );

   // divider for basis terms and the final projection
   ncpe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // back: stores, span search, basis triangle, weighted sums
   ncpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ncpe_front.sv =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - front end
// Takes request words, drops those that do nothing, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nurbs_curve_point_eval_unit_macros.svh"

module ncpe_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire ncpe_pkg::req_type req_data,
   output logic                  q_valid,
   input  wire                   q_ready,
   output ncpe_pkg::req_type     q_data
);

   ncpe_pkg::req_type    fifo_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 keep;
   logic                 push;
   logic                 pop;
   ncpe_pkg::opcode_type op;

   always_comb begin
      op   = ncpe_pkg::opcode_type'(req_data.opcode);
      keep = 1'b0;
      unique case (op)
         ncpe_pkg::OP_KNOT:  keep = (req_data.slot < ncpe_pkg::SlotW'(ncpe_pkg::KnotDepth));
         ncpe_pkg::OP_POINT: keep = (req_data.slot < ncpe_pkg::SlotW'(ncpe_pkg::MaxPoints));
         ncpe_pkg::OP_EVAL:  keep = 1'b1;
         default:            keep = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_data    = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= req_data;
      end
   end

   `NCPE_ASSERT(a_fifo_empty_ptrs, clock, reset, (cnt_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
   `NCPE_ASSERT(a_fifo_full_ptrs, clock, reset, (cnt_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
   `NCPE_NEVER(a_fifo_push_full, clock, reset, push && (cnt_ff == 2'd2))

endmodule

`default_nettype wire

// ===== rtl/core/ncpe_div.sv =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - signed divider
// Restoring divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ncpe_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire ncpe_pkg::div_req_type div_req,
   output ncpe_pkg::div_rsp_type     div_rsp
);

   localparam int W = ncpe_pkg::DivW;
   localparam int D = ncpe_pkg::DvsW;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ncpe_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                 quo_ff, quo_in;
   logic [D-1:0]                 rem_ff, rem_in;
   logic [D-1:0]                 dvs_ff, dvs_in;
   logic                         neg_ff, neg_in;
   logic [D:0]                   rem_sh;
   logic [D+1:0]                 diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, quo_ff[W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, dvs_ff};
      if (div_req.start) begin
         // load magnitudes, remember the sign of the quotient
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend[W-1] ? W'(-div_req.dividend) : W'(div_req.dividend);
         dvs_in  = div_req.divisor[D-1] ? D'(-div_req.divisor) : D'(div_req.divisor);
         neg_in  = div_req.dividend[W-1] ^ div_req.divisor[D-1];
      end else if (busy_ff) begin
         if (!diff[D+1]) begin
            rem_in = diff[D-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[D-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ncpe_pkg::DivCntW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

`default_nettype wire

// ===== rtl/core/ncpe_back.sv =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - back end
// Holds the stores and settings, runs the evaluation sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nurbs_curve_point_eval_unit_macros.svh"

module ncpe_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire [ncpe_pkg::CsrIdxW-1:0]  csr_index,
   input  wire [ncpe_pkg::CsrDataW-1:0] csr_wdata,
   input  wire                   q_valid,
   output logic                  q_ready,
   input  wire ncpe_pkg::req_type q_data,
   output ncpe_pkg::div_req_type div_req,
   input  wire ncpe_pkg::div_rsp_type div_rsp,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ncpe_pkg::rsp_type     rsp_data
);

   localparam int KW  = ncpe_pkg::KnotW;
   localparam int CW  = ncpe_pkg::CoordW;
   localparam int WW  = ncpe_pkg::WeightW;
   localparam int KIW = ncpe_pkg::KnotIdxW;
   localparam int PIW = ncpe_pkg::PtIdxW;
   localparam int DfW = KW + 1;
   localparam int DnW = KW + 2;
   localparam int WpW = WW + CW + 1;
   localparam int WnW = WpW - 20;
   localparam int MD  = ncpe_pkg::MaxDegree;

   function automatic logic sat_hit(input logic signed [63:0] v);
      return !((&v[63:31]) || (~|v[63:31]));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (sat_hit(v)) begin
         return v[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      return v[31:0];
   endfunction

   // stores
   logic [KW-1:0] knot_mem [ncpe_pkg::KnotDepth];
   logic [CW-1:0] px_mem   [ncpe_pkg::MaxPoints];
   logic [CW-1:0] py_mem   [ncpe_pkg::MaxPoints];
   logic [CW-1:0] pz_mem   [ncpe_pkg::MaxPoints];
   logic [WW-1:0] w_mem    [ncpe_pkg::MaxPoints];
   logic [KW-1:0] knot_rd_ff;
   logic [CW-1:0] px_rd_ff, py_rd_ff, pz_rd_ff;
   logic [WW-1:0] w_rd_ff;
   logic [KIW-1:0] knot_addr;
   logic [PIW-1:0] pt_addr;
   logic           knot_we;
   logic           pt_we;

   ncpe_pkg::state_type state_ff, state_in;
   logic [ncpe_pkg::DegW-1:0]   deg_ff;
   logic [ncpe_pkg::CountW-1:0] count_ff;

   logic [KW-1:0]  t_ff, t_in;
   logic [1:0]     p_ff, p_in;
   logic [PIW-1:0] n_ff, n_in;
   logic [KW-1:0]  hik_ff, hik_in;
   logic [KIW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [PIW-1:0] span_ff, span_in;
   logic [1:0]     jj_ff, jj_in, rr_ff, rr_in, ii_ff, ii_in, fc_ff, fc_in;
   logic           side_ff, side_in;
   logic signed [DfW-1:0] left_ff [1:MD];
   logic signed [DfW-1:0] left_in [1:MD];
   logic signed [DfW-1:0] right_ff [1:MD];
   logic signed [DfW-1:0] right_in [1:MD];
   logic signed [CW-1:0]  nb_ff [0:MD];
   logic signed [CW-1:0]  nb_in [0:MD];
   logic signed [DnW-1:0] den_ff, den_in;
   logic signed [CW-1:0]  old_ff, old_in, saved_ff, saved_in;
   logic signed [63:0]    q1_ff, q1_in, prod_ff, prod_in;
   logic signed [WpW-1:0] wprod_ff, wprod_in;
   logic signed [WnW-1:0] wn_ff, wn_in;
   logic signed [CW-1:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [63:0]    sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic signed [31:0]    sw_ff, sw_in;
   logic signed [CW-1:0]  rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   ncpe_pkg::status_type  stat_ff, stat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ncpe_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [1:0]             p_eff;
   logic [ncpe_pkg::CountW-1:0] pc;
   logic [KIW:0]           mid_sum;
   logic [1:0]             jr_idx, r1_idx, nb_idx;
   logic signed [DfW-1:0]  lsel, rsel;
   logic signed [CW-1:0]   nb_rd;
   logic signed [CW-1:0]   mul_a, mul_b;
   logic signed [63:0]     mul_p;
   logic signed [WpW-1:0]  wsum;
   logic signed [63:0]     tri_sum;
   ncpe_pkg::opcode_type   q_op;

   always_comb begin
      p_eff = (deg_ff == 2'd0) ? 2'd1 : deg_ff;
      pc    = (count_ff > ncpe_pkg::CountW'(ncpe_pkg::MaxPoints)) ?
              ncpe_pkg::CountW'(ncpe_pkg::MaxPoints) : count_ff;
      if (pc < {5'd0, p_eff} + 7'd1) begin
         pc = {5'd0, p_eff} + 7'd1;
      end
   end

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign jr_idx  = jj_ff - rr_ff;
   assign r1_idx  = rr_ff + 2'd1;
   assign lsel    = left_ff[jr_idx];
   assign rsel    = right_ff[r1_idx];
   assign nb_idx  = (state_ff == ncpe_pkg::S_WN_MUL) ? ii_ff : rr_ff;
   assign nb_rd   = nb_ff[nb_idx];
   assign mul_p   = mul_a * mul_b;
   assign wsum    = wprod_ff + $signed({{(WpW-20){1'b0}}, {20{wprod_ff[WpW-1]}}});
   assign tri_sum = {{32{saved_ff[CW-1]}}, saved_ff} + q1_ff;
   assign q_op    = ncpe_pkg::opcode_type'(q_data.opcode);

   always_comb begin
      state_in = state_ff;
      t_in = t_ff; p_in = p_ff; n_in = n_ff; hik_in = hik_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; span_in = span_ff;
      jj_in = jj_ff; rr_in = rr_ff; ii_in = ii_ff; fc_in = fc_ff; side_in = side_ff;
      left_in = left_ff; right_in = right_ff; nb_in = nb_ff;
      den_in = den_ff; old_in = old_ff; saved_in = saved_ff; q1_in = q1_ff;
      prod_in = prod_ff; wprod_in = wprod_ff; wn_in = wn_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff; sw_in = sw_ff;
      rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff; stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_ready   = 1'b0;
      knot_we   = 1'b0;
      pt_we     = 1'b0;
      knot_addr = '0;
      pt_addr   = '0;
      mul_a     = '0;
      mul_b     = '0;
      div_req   = '0;
      unique case (state_ff)
         ncpe_pkg::S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               case (q_op)
                  ncpe_pkg::OP_KNOT:  knot_we = 1'b1;
                  ncpe_pkg::OP_POINT: pt_we = 1'b1;
                  ncpe_pkg::OP_EVAL: begin
                     t_in  = q_data.param_value;
                     p_in  = p_eff;
                     n_in  = PIW'(pc - 7'd1);
                     nb_in = '{default: '0};
                     nb_in[0] = 32'sh40000000;
                     sx_in = '0; sy_in = '0; sz_in = '0; sw_in = '0;
                     state_in = ncpe_pkg::S_RD_HI;
                  end
                  default: ;
               endcase
            end
         end
         ncpe_pkg::S_RD_HI: begin
            knot_addr = KIW'({1'b0, n_ff} + 7'd1);
            state_in  = ncpe_pkg::S_RD_LO;
         end
         ncpe_pkg::S_RD_LO: begin
            knot_addr = KIW'(p_ff);
            hik_in    = knot_rd_ff;
            state_in  = ncpe_pkg::S_CLAMP;
         end
         ncpe_pkg::S_CLAMP: begin
            jj_in = 2'd1;
            side_in = 1'b0;
            if (t_ff >= hik_ff) begin
               t_in = hik_ff;
               span_in = n_ff;
               state_in = ncpe_pkg::S_LR_RD;
            end else if (t_ff < knot_rd_ff) begin
               t_in = knot_rd_ff;
               span_in = PIW'(p_ff);
               state_in = ncpe_pkg::S_LR_RD;
            end else begin
               lo_in = KIW'(p_ff);
               hi_in = KIW'({1'b0, n_ff} + 7'd1);
               state_in = ncpe_pkg::S_PROBE;
            end
         end
         ncpe_pkg::S_PROBE: begin
            // bisect until the window is one knot wide
            if (hi_ff - lo_ff > KIW'(1)) begin
               mid_in    = mid_sum[KIW:1];
               knot_addr = mid_sum[KIW:1];
               state_in  = ncpe_pkg::S_CMP;
            end else begin
               span_in  = lo_ff[PIW-1:0];
               state_in = ncpe_pkg::S_LR_RD;
            end
         end
         ncpe_pkg::S_CMP: begin
            if (t_ff < knot_rd_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff;
            end
            state_in = ncpe_pkg::S_PROBE;
         end
         ncpe_pkg::S_LR_RD: begin
            knot_addr = side_ff ? KIW'({1'b0, span_ff} + {5'd0, jj_ff}) :
                                  KIW'({1'b0, span_ff} + 7'd1 - {5'd0, jj_ff});
            state_in  = ncpe_pkg::S_LR_CAP;
         end
         ncpe_pkg::S_LR_CAP: begin
            if (!side_ff) begin
               left_in[jj_ff] = $signed({1'b0, t_ff}) - $signed({1'b0, knot_rd_ff});
               side_in  = 1'b1;
               state_in = ncpe_pkg::S_LR_RD;
            end else begin
               right_in[jj_ff] = $signed({1'b0, knot_rd_ff}) - $signed({1'b0, t_ff});
               side_in = 1'b0;
               if (jj_ff == p_ff) begin
                  jj_in = 2'd1;
                  rr_in = 2'd0;
                  saved_in = '0;
                  state_in = ncpe_pkg::S_TRI_DEN;
               end else begin
                  jj_in = jj_ff + 2'd1;
                  state_in = ncpe_pkg::S_LR_RD;
               end
            end
         end
         ncpe_pkg::S_TRI_DEN: begin
            den_in   = {rsel[DfW-1], rsel} + {lsel[DfW-1], lsel};
            old_in   = nb_rd;
            state_in = ncpe_pkg::S_TRI_MUL1;
         end
         ncpe_pkg::S_TRI_MUL1: begin
            if (den_ff == '0) begin
               // zero denominator: both terms drop out
               nb_in[rr_ff] = saved_ff;
               saved_in = '0;
               state_in = ncpe_pkg::S_TRI_NEXT;
            end else begin
               mul_a    = CW'(rsel);
               mul_b    = old_ff;
               prod_in  = mul_p;
               state_in = ncpe_pkg::S_TRI_GO1;
            end
         end
         ncpe_pkg::S_TRI_GO1: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = ncpe_pkg::DvsW'(den_ff);
            state_in = ncpe_pkg::S_TRI_W1;
         end
         ncpe_pkg::S_TRI_W1: begin
            if (div_rsp.done) begin
               q1_in    = div_rsp.quotient;
               state_in = ncpe_pkg::S_TRI_MUL2;
            end
         end
         ncpe_pkg::S_TRI_MUL2: begin
            mul_a    = CW'(lsel);
            mul_b    = old_ff;
            prod_in  = mul_p;
            state_in = ncpe_pkg::S_TRI_GO2;
         end
         ncpe_pkg::S_TRI_GO2: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = ncpe_pkg::DvsW'(den_ff);
            state_in = ncpe_pkg::S_TRI_W2;
         end
         ncpe_pkg::S_TRI_W2: begin
            if (div_rsp.done) begin
               nb_in[rr_ff] = sat32(tri_sum);
               saved_in = sat32(div_rsp.quotient);
               state_in = ncpe_pkg::S_TRI_NEXT;
            end
         end
         ncpe_pkg::S_TRI_NEXT: begin
            state_in = ncpe_pkg::S_TRI_DEN;
            if (rr_ff == jj_ff - 2'd1) begin
               nb_in[jj_ff] = saved_ff;
               rr_in = 2'd0;
               saved_in = '0;
               if (jj_ff == p_ff) begin
                  ii_in = 2'd0;
                  state_in = ncpe_pkg::S_PT_RD;
               end else begin
                  jj_in = jj_ff + 2'd1;
               end
            end else begin
               rr_in = rr_ff + 2'd1;
            end
         end
         ncpe_pkg::S_PT_RD: begin
            pt_addr  = span_ff - {4'd0, p_ff} + {4'd0, ii_ff};
            state_in = ncpe_pkg::S_WN_MUL;
         end
         ncpe_pkg::S_WN_MUL: begin
            mul_a    = CW'($signed({1'b0, w_rd_ff}));
            mul_b    = nb_rd;
            wprod_in = mul_p[WpW-1:0];
            cx_in = px_rd_ff; cy_in = py_rd_ff; cz_in = pz_rd_ff;
            state_in = ncpe_pkg::S_WN_SHIFT;
         end
         ncpe_pkg::S_WN_SHIFT: begin
            // divide by 2^20, rounding toward zero
            wn_in    = wsum[WpW-1:20];
            state_in = ncpe_pkg::S_MX;
         end
         ncpe_pkg::S_MX: begin
            mul_a = CW'(wn_ff); mul_b = cx_ff; prod_in = mul_p;
            state_in = ncpe_pkg::S_MY;
         end
         ncpe_pkg::S_MY: begin
            sx_in = sx_ff + prod_ff;
            mul_a = CW'(wn_ff); mul_b = cy_ff; prod_in = mul_p;
            state_in = ncpe_pkg::S_MZ;
         end
         ncpe_pkg::S_MZ: begin
            sy_in = sy_ff + prod_ff;
            mul_a = CW'(wn_ff); mul_b = cz_ff; prod_in = mul_p;
            state_in = ncpe_pkg::S_AZ;
         end
         ncpe_pkg::S_AZ: begin
            sz_in = sz_ff + prod_ff;
            sw_in = sw_ff + 32'(wn_ff);
            if (ii_ff == p_ff) begin
               state_in = ncpe_pkg::S_FIN;
            end else begin
               ii_in = ii_ff + 2'd1;
               state_in = ncpe_pkg::S_PT_RD;
            end
         end
         ncpe_pkg::S_FIN: begin
            fc_in = 2'd0;
            if (sw_ff == '0) begin
               rx_in = '0; ry_in = '0; rz_in = '0;
               stat_in  = ncpe_pkg::STAT_ZERO_W;
               state_in = ncpe_pkg::S_DONE;
            end else begin
               stat_in  = ncpe_pkg::STAT_OK;
               state_in = ncpe_pkg::S_FGO;
            end
         end
         ncpe_pkg::S_FGO: begin
            div_req.start   = 1'b1;
            div_req.divisor = sw_ff;
            case (fc_ff)
               2'd0:    div_req.dividend = sx_ff;
               2'd1:    div_req.dividend = sy_ff;
               default: div_req.dividend = sz_ff;
            endcase
            state_in = ncpe_pkg::S_FW;
         end
         ncpe_pkg::S_FW: begin
            if (div_rsp.done) begin
               case (fc_ff)
                  2'd0:    rx_in = sat32(div_rsp.quotient);
                  2'd1:    ry_in = sat32(div_rsp.quotient);
                  default: rz_in = sat32(div_rsp.quotient);
               endcase
               if (sat_hit(div_rsp.quotient)) begin
                  stat_in = ncpe_pkg::STAT_SAT;
               end
               if (fc_ff == 2'd2) begin
                  state_in = ncpe_pkg::S_DONE;
               end else begin
                  fc_in = fc_ff + 2'd1;
                  state_in = ncpe_pkg::S_FGO;
               end
            end
         end
         ncpe_pkg::S_DONE: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.pos_x  = rx_ff;
               rsp_data_in.pos_y  = ry_ff;
               rsp_data_in.pos_z  = rz_ff;
               rsp_data_in.status = stat_ff;
               state_in = ncpe_pkg::S_IDLE;
            end
         end
         default: state_in = ncpe_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncpe_pkg::S_IDLE;
         deg_ff       <= 2'd1;
         count_ff     <= 7'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == ncpe_pkg::CSR_DEGREE) begin
            deg_ff <= csr_wdata[ncpe_pkg::DegW-1:0];
         end
         if (csr_we && csr_index == ncpe_pkg::CSR_COUNT) begin
            count_ff <= csr_wdata[ncpe_pkg::CountW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; p_ff <= p_in; n_ff <= n_in; hik_ff <= hik_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; span_ff <= span_in;
      jj_ff <= jj_in; rr_ff <= rr_in; ii_ff <= ii_in; fc_ff <= fc_in;
      side_ff <= side_in;
      left_ff <= left_in; right_ff <= right_in; nb_ff <= nb_in;
      den_ff <= den_in; old_ff <= old_in; saved_ff <= saved_in; q1_ff <= q1_in;
      prod_ff <= prod_in; wprod_ff <= wprod_in; wn_ff <= wn_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in; sw_ff <= sw_in;
      rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in; stat_ff <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (knot_we) begin
         knot_mem[q_data.slot[KIW-1:0]] <= q_data.param_value;
      end
      knot_rd_ff <= knot_mem[knot_addr];
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         px_mem[q_data.slot[PIW-1:0]] <= q_data.coord_x;
         py_mem[q_data.slot[PIW-1:0]] <= q_data.coord_y;
         pz_mem[q_data.slot[PIW-1:0]] <= q_data.coord_z;
         w_mem[q_data.slot[PIW-1:0]]  <= q_data.point_weight;
      end
      px_rd_ff <= px_mem[pt_addr];
      py_rd_ff <= py_mem[pt_addr];
      pz_rd_ff <= pz_mem[pt_addr];
      w_rd_ff  <= w_mem[pt_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NCPE_ASSERT(a_idle_div_quiet, clock, reset, (state_ff == ncpe_pkg::S_IDLE) |-> !div_rsp.busy)
   `NCPE_NEVER(a_div_restart, clock, reset, div_req.start && div_rsp.busy)
   `NCPE_ASSERT(a_rsp_from_done, clock, reset, (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ncpe_pkg::S_DONE))

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// NURBS curve point evaluator - self-checking testbench
// Loads knots and weighted control points, evaluates curve points under a
// range of degree and point-count settings, and checks every returned point
// against a fixed-point predictor of the span search, the basis triangle
// and the rational division.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   ncpe_pkg::req_type             req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   ncpe_pkg::rsp_type             rsp_data;
   logic                          csr_we = 1'b0;
   logic [ncpe_pkg::CsrIdxW-1:0]  csr_index = ncpe_pkg::CSR_DEGREE;
   logic [ncpe_pkg::CsrDataW-1:0] csr_wdata = '0;

   nurbs_curve_point_eval_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mirror of the block's state, updated as each word is accepted
   logic [ncpe_pkg::KnotW-1:0]         knot_mem [ncpe_pkg::KnotDepth];
   logic signed [ncpe_pkg::CoordW-1:0] px_mem [ncpe_pkg::MaxPoints];
   logic signed [ncpe_pkg::CoordW-1:0] py_mem [ncpe_pkg::MaxPoints];
   logic signed [ncpe_pkg::CoordW-1:0] pz_mem [ncpe_pkg::MaxPoints];
   logic [ncpe_pkg::WeightW-1:0]       weight_mem [ncpe_pkg::MaxPoints];
   logic [ncpe_pkg::DegW-1:0]          cfg_degree = 2'd1;
   logic [ncpe_pkg::CountW-1:0]        cfg_count = 7'd2;

   // knot values as planned on the stimulus side, to aim t at real knots
   int unsigned plan_knot [ncpe_pkg::KnotDepth];

   ncpe_pkg::req_type word_backlog [$];
   ncpe_pkg::rsp_type expected_points [$];

   int  cycle_count = 0;
   int  words_pushed = 0;
   int  words_taken = 0;
   int  points_checked = 0;
   int  mismatches = 0;
   int  setups = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint knot_at(int k);
      return longint'(knot_mem[k]);
   endfunction

   function automatic ncpe_pkg::rsp_type curve_point(logic [ncpe_pkg::KnotW-1:0] tin);
      longint t, den, old, saved, wn, sx, sy, sz, sw, q, px, py, pz;
      longint basis [ncpe_pkg::MaxDegree+1];
      longint lft [ncpe_pkg::MaxDegree+1];
      longint rgt [ncpe_pkg::MaxDegree+1];
      int p, n, span, lo, hi, mid, idx;
      bit hit;
      ncpe_pkg::rsp_type res;
      p = cfg_degree;
      if (p < 1) p = 1;
      if (p > ncpe_pkg::MaxDegree) p = ncpe_pkg::MaxDegree;
      n = cfg_count;
      if (n > ncpe_pkg::MaxPoints) n = ncpe_pkg::MaxPoints;
      if (n < p + 1) n = p + 1;
      n = n - 1;
      t = longint'(tin);
      // clamp t into the valid knot range, else bisect for the span
      if (t >= knot_at(n + 1)) begin
         t = knot_at(n + 1);
         span = n;
      end else if (t < knot_at(p)) begin
         t = knot_at(p);
         span = p;
      end else begin
         lo = p;
         hi = n + 1;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (t < knot_at(mid)) hi = mid;
            else lo = mid;
         end
         span = lo;
      end
      for (int j = 0; j <= ncpe_pkg::MaxDegree; j++) begin
         basis[j] = 0;
         lft[j] = 0;
         rgt[j] = 0;
      end
      basis[0] = 64'sd1 << 30;
      for (int j = 1; j <= p; j++) begin
         saved = 0;
         lft[j] = t - knot_at(span + 1 - j);
         rgt[j] = knot_at(span + j) - t;
         for (int r = 0; r < j; r++) begin
            den = rgt[r+1] + lft[j-r];
            old = basis[r];
            if (den == 0) begin
               // a zero denominator kills both terms it feeds
               basis[r] = clip32(saved);
               saved = 0;
            end else begin
               basis[r] = clip32(saved + (rgt[r+1] * old) / den);
               saved = clip32((lft[j-r] * old) / den);
            end
         end
         basis[j] = saved;
      end
      sx = 0; sy = 0; sz = 0; sw = 0;
      for (int i = 0; i <= p; i++) begin
         idx = span - p + i;
         wn = (longint'(weight_mem[idx]) * basis[i]) / (64'sd1 << 20);
         sx += wn * longint'(px_mem[idx]);
         sy += wn * longint'(py_mem[idx]);
         sz += wn * longint'(pz_mem[idx]);
         sw += wn;
      end
      hit = 1'b0;
      if (sw == 0) begin
         res.pos_x = '0;
         res.pos_y = '0;
         res.pos_z = '0;
         res.status = ncpe_pkg::STAT_ZERO_W;
      end else begin
         q = sx / sw; px = clip32(q); hit |= (px != q);
         q = sy / sw; py = clip32(q); hit |= (py != q);
         q = sz / sw; pz = clip32(q); hit |= (pz != q);
         res.pos_x = px[31:0];
         res.pos_y = py[31:0];
         res.pos_z = pz[31:0];
         res.status = hit ? ncpe_pkg::STAT_SAT : ncpe_pkg::STAT_OK;
      end
      return res;
   endfunction

   function automatic void absorb_word(ncpe_pkg::req_type w);
      case (ncpe_pkg::opcode_type'(w.opcode))
         ncpe_pkg::OP_KNOT: begin
            if (w.slot < ncpe_pkg::KnotDepth) knot_mem[w.slot] = w.param_value;
         end
         ncpe_pkg::OP_POINT: begin
            if (w.slot < ncpe_pkg::MaxPoints) begin
               px_mem[w.slot[ncpe_pkg::PtIdxW-1:0]] = w.coord_x;
               py_mem[w.slot[ncpe_pkg::PtIdxW-1:0]] = w.coord_y;
               pz_mem[w.slot[ncpe_pkg::PtIdxW-1:0]] = w.coord_z;
               weight_mem[w.slot[ncpe_pkg::PtIdxW-1:0]] = w.point_weight;
            end
         end
         ncpe_pkg::OP_EVAL: expected_points = {expected_points, curve_point(w.param_value)};
         default: ;
      endcase
   endfunction

   // idle with a 14 percent chance, never inside the quiet window
   function automatic bit idle_now();
      if (cycle_count >= 40000 && cycle_count < 90000) return 1'b0;
      return $urandom_range(99) < 14;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: hold each word until accepted, then advance the backlog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_word(req_data);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (word_backlog.size() > 0 && !idle_now()) begin
               req_data <= word_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each point, and once hold off the result side for long
   // enough that the input queue fills and stalls the sender
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t unexpected point: actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               automatic ncpe_pkg::rsp_type want = expected_points.pop_front();
               if (rsp_data.pos_x !== want.pos_x || rsp_data.pos_y !== want.pos_y ||
                   rsp_data.pos_z !== want.pos_z || rsp_data.status !== want.status) begin
                  $display("%0t point mismatch: expected x %h y %h z %h st %0d",
                           $time, want.pos_x, want.pos_y, want.pos_z, want.status);
                  $display("%0t                 actual   x %h y %h z %h st %0d",
                           $time, rsp_data.pos_x, rsp_data.pos_y, rsp_data.pos_z,
                           rsp_data.status);
                  mismatches++;
               end
            end
            points_checked++;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && points_checked >= 6 && word_backlog.size() >= 6) begin
            hold_left <= 5000;
            long_hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_now();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic put_knot(int s, int unsigned v);
      ncpe_pkg::req_type w;
      w = '0;
      w.opcode = ncpe_pkg::OP_KNOT;
      w.slot = ncpe_pkg::SlotW'(s);
      w.param_value = ncpe_pkg::KnotW'(v);
      w.coord_x = $urandom;
      w.point_weight = ncpe_pkg::WeightW'($urandom);
      if (s < ncpe_pkg::KnotDepth) plan_knot[s] = v;
      word_backlog = {word_backlog, w};
      words_pushed++;
   endtask

   task automatic put_point(int s, int x, int y, int z, int unsigned wt);
      ncpe_pkg::req_type w;
      w = '0;
      w.opcode = ncpe_pkg::OP_POINT;
      w.slot = ncpe_pkg::SlotW'(s);
      w.param_value = ncpe_pkg::KnotW'($urandom_range(0, 8388608));
      w.coord_x = x;
      w.coord_y = y;
      w.coord_z = z;
      w.point_weight = ncpe_pkg::WeightW'(wt);
      word_backlog = {word_backlog, w};
      words_pushed++;
   endtask

   task automatic put_eval(int unsigned v);
      ncpe_pkg::req_type w;
      w = '0;
      w.opcode = ncpe_pkg::OP_EVAL;
      w.slot = ncpe_pkg::SlotW'($urandom);
      w.param_value = ncpe_pkg::KnotW'(v);
      word_backlog = {word_backlog, w};
      words_pushed++;
   endtask

   task automatic put_noise();
      ncpe_pkg::req_type w;
      w.opcode = ncpe_pkg::OP_NONE;
      w.slot = ncpe_pkg::SlotW'($urandom);
      w.param_value = ncpe_pkg::KnotW'($urandom);
      w.coord_x = $urandom;
      w.coord_y = $urandom;
      w.coord_z = $urandom;
      w.point_weight = ncpe_pkg::WeightW'($urandom);
      word_backlog = {word_backlog, w};
      words_pushed++;
   endtask

   // wait until every word is taken and every point returned, then let
   // writes settle
   task automatic drain();
      while (words_taken != words_pushed || expected_points.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic set_curve(int deg, int cnt);
      drain();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= ncpe_pkg::CSR_DEGREE;
      csr_wdata <= ncpe_pkg::CsrDataW'(deg);
      cfg_degree = ncpe_pkg::DegW'(deg);
      @(posedge clock);
      csr_index <= ncpe_pkg::CSR_COUNT;
      csr_wdata <= ncpe_pkg::CsrDataW'(cnt);
      cfg_count = ncpe_pkg::CountW'(cnt);
      @(posedge clock);
      csr_we <= 1'b0;
      setups++;
   endtask

   function automatic int rand_coord();
      if ($urandom_range(1)) return int'($urandom);
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   function automatic int unsigned rand_weight();
      case ($urandom_range(9))
         0: return 1;
         1: return 65535;
         default: return $urandom_range(1, 65535);
      endcase
   endfunction

   function automatic int unsigned rand_param();
      case ($urandom_range(9))
         0: return 0;
         1: return 8388608;
         2, 3: return plan_knot[$urandom_range(ncpe_pkg::KnotDepth - 1)];
         default: return $urandom_range(0, 8388608);
      endcase
   endfunction

   initial begin
      int deg, cnt, p, n, last, shape, evals;
      int unsigned v, stride;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill every store entry first so that no unwritten entry is ever read
      v = 0;
      for (int k = 0; k < ncpe_pkg::KnotDepth; k++) begin
         put_knot(k, v);
         v = v + 120000;
      end
      for (int k = 0; k < ncpe_pkg::MaxPoints; k++)
         put_point(k, rand_coord(), rand_coord(), rand_coord(), rand_weight());

      // directed: all knots equal gives a zero weight sum
      set_curve(1, 2);
      for (int k = 0; k < 4; k++) put_knot(k, 0);
      put_eval(0);
      put_eval(8388608);
      // degree zero is taken as one, count zero as degree plus one
      set_curve(0, 0);
      for (int k = 0; k < 4; k++) put_knot(k, k * 2796202);
      put_point(0, 32'sh7fffffff, 32'sh80000000, 0, 65535);
      put_point(1, 32'sh80000000, 32'sh7fffffff, 1, 1);
      put_eval(0);
      put_eval(4194304);
      put_eval(8388608);
      // ignored words: opcode three and out-of-range slots
      put_noise();
      put_knot(127, 8388608);
      put_point(67, -1, -1, -1, 65535);
      put_point(64, 5, 5, 5, 1);
      put_eval(3000000);
      // top degree, full point count, unordered knots
      set_curve(3, 64);
      for (int k = 0; k < ncpe_pkg::KnotDepth; k++) put_knot(k, $urandom_range(0, 8388608));
      put_eval(0);
      put_eval(8388608);
      put_eval(plan_knot[3]);
      // point count above the store size clamps to the store size
      set_curve(2, 127);
      put_eval($urandom_range(0, 8388608));

      // random setups until the word budget is spent
      while (words_pushed < 1900) begin
         deg = $urandom_range(0, 3);
         case ($urandom_range(9))
            0: cnt = $urandom_range(65, 127);
            1, 2: cnt = $urandom_range(9, 64);
            default: cnt = $urandom_range(0, 8);
         endcase
         set_curve(deg, cnt);
         p = (deg < 1) ? 1 : deg;
         n = (cnt > ncpe_pkg::MaxPoints) ? ncpe_pkg::MaxPoints : cnt;
         if (n < p + 1) n = p + 1;
         last = n + p;                  // one above the highest knot index in use
         shape = $urandom_range(9);
         stride = 2 * (8388608 / (last + 1)) + 1;
         v = 0;
         if (shape != 9) begin
            for (int k = 0; k <= last; k++) begin
               case (shape)
                  6: begin               // clamped ends
                     if (k <= p) v = 0;
                     else if (k >= last - p) v = 8388608;
                     else v = v + $urandom_range(0, stride);
                  end
                  7: v = $urandom_range(0, 8388608);          // unordered
                  8: v = v + $urandom_range(0, 2) * 1000000;  // repeated knots
                  default: v = v + $urandom_range(0, stride);
               endcase
               if (v > 8388608) v = 8388608;
               put_knot(k, v);
            end
         end
         for (int k = 0; k < n; k++)
            if ($urandom_range(1))
               put_point(k, rand_coord(), rand_coord(), rand_coord(), rand_weight());
         if ($urandom_range(9) == 0) put_noise();
         if ($urandom_range(9) == 0) put_point($urandom_range(64, 127), rand_coord(),
                                               rand_coord(), rand_coord(), rand_weight());
         if ($urandom_range(9) == 0) put_knot($urandom_range(68, 127), $urandom_range(0, 8388608));
         evals = $urandom_range(6, 14);
         for (int e = 0; e < evals; e++) put_eval(rand_param());
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d words across %0d curve setups; checked %0d evaluated points.",
               words_taken, setups, points_checked);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #250000000;
      $display("Run stopped at the time limit with %0d points still owed.",
               expected_points.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
